>>> src/lpfd_pkg.sv
package lpfd_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEF = 1024;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_TYPE     = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hF7;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hFE;
  localparam logic [BYTE_W-1:0] ADC_TYPE_RST     = 8'hB3;

  // Reported status codes.
  localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IN_FRAME = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  payload_index;
    logic                frame_end;
    logic                adc_payload;
  } res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
    logic [BYTE_W-1:0] adc_type_code;
  } cfg_t;

  function automatic logic [STATUS_W-1:0] status_of(input phase_t ph);
    logic [STATUS_W-1:0] st;
    unique case (ph)
      PH_WAIT:              st = ST_WAIT;
      PH_LEN_HI, PH_LEN_LO: st = ST_LENGTH;
      PH_DATA:              st = ST_IN_FRAME;
      PH_DONE:              st = ST_COMPLETE;
      default:              st = ST_ERROR;
    endcase
    return st;
  endfunction

endpackage

>>> src/lpfd_parser.sv
module lpfd_parser
  import lpfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              action,
  input  logic [BYTE_W-1:0] byte_in,
  input  cfg_t              cfg,
  output res_t              res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] ftype_r, ftype_nxt;

  logic [15:0]      len_full;
  logic             len_ok;
  logic [CNT_W-1:0] cnt_inc;
  logic             last_byte;
  logic             in_adc_span;

  assign len_full  = {len_hi_r, byte_in};
  assign len_ok    = (len_full != 16'd0) && (len_full <= 16'(MAX_FRAME_LEN));
  assign cnt_inc   = cnt_r + 1'b1;
  assign last_byte = (cnt_inc == len_r);
  // Bytes 1 through len-4 of an ADC-type frame carry samples.
  assign in_adc_span = (ftype_r == cfg.adc_type_code) && (cnt_r != '0) &&
                       ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(4) <= (CNT_W+1)'(len_r));

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    ftype_nxt  = ftype_r;
    if (action) begin
      phase_nxt  = PH_WAIT;
      len_hi_nxt = '0;
      len_nxt    = '0;
      cnt_nxt    = '0;
      ftype_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          if (byte_in == cfg.start_marker) phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_nxt = byte_in;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          // A length within range fits the counter; any other is truncated here but leads to the error phase.
          len_nxt   = CNT_W'(len_full);
          cnt_nxt   = '0;
          phase_nxt = len_ok ? PH_DATA : PH_ERROR;
        end
        PH_DATA: begin
          if (cnt_r == '0) ftype_nxt = byte_in;
          cnt_nxt = cnt_inc;
          if (last_byte) phase_nxt = (byte_in == cfg.end_marker) ? PH_DONE : PH_ERROR;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result of the item being accepted.
  always_comb begin
    res        = '0;
    res.status = status_of(phase_nxt);
    if (!action && phase_r == PH_DATA) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = byte_in;
      res.payload_index = INDEX_W'(cnt_r);
      res.frame_end     = last_byte;
      res.adc_payload   = in_adc_span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      len_hi_r <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      ftype_r  <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      ftype_r  <= ftype_nxt;
    end
  end

endmodule

>>> src/lpfd_skid.sv
module lpfd_skid
  import lpfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  res_t in_res,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;
  logic out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= in_push;
        end else begin
          out_valid_r <= in_push;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= in_push;
      end else if (in_push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
        if (in_push) skid_res_r <= in_res;
      end else if (in_push) begin
        out_res_r <= in_res;
      end
    end else if (!out_valid_r) begin
      if (in_push) out_res_r <= in_res;
    end else if (in_push) begin
      skid_res_r <= in_res;
    end
  end

endmodule

>>> src/length_prefixed_frame_deframer.sv
// Byte-stream deframer: each accepted item is either a byte or a restart and yields exactly one
// result item. A frame is a start marker, a big-endian 16-bit length and that many frame bytes,
// the last of which must equal the end marker. Frame bytes are streamed out with their index,
// and bytes 1 through len-4 of a frame whose first byte equals the ADC type code are flagged.
// A length of zero or above MAX_FRAME_LEN ends in error. After completion or error the status
// holds until a restart item. One item is taken every cycle while in_stall is low. A two-entry
// output buffer lets input keep flowing after out_stall rises; in_stall marks its spare entry
// full. The user must write markers via cfg_* only while idle; the block does not enforce it.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [BYTE_W-1:0]    in_byte_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_payload_valid,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [INDEX_W-1:0]   out_payload_index,
  output logic                 out_frame_end,
  output logic                 out_adc_payload
);

  cfg_t cfg_r;
  logic in_acc;
  logic buf_full;
  res_t step_res;
  res_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker  <= START_MARKER_RST;
      cfg_r.end_marker    <= END_MARKER_RST;
      cfg_r.adc_type_code <= ADC_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_MARKER: cfg_r.start_marker  <= cfg_wdata;
        REG_END_MARKER:   cfg_r.end_marker    <= cfg_wdata;
        REG_ADC_TYPE:     cfg_r.adc_type_code <= cfg_wdata;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  lpfd_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .action  (in_action),
    .byte_in (in_byte_in),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  lpfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_acc),
    .in_res    (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_frame_end     = out_res.frame_end;
  assign out_adc_payload   = out_res.adc_payload;

`ifndef SYNTHESIS
  // The spare entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("output buffer spare entry holds data with no result waiting");

  // A frame byte can only leave the parser while in a frame or on its last byte.
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |->
      (out_status == ST_IN_FRAME || out_status == ST_COMPLETE || out_status == ST_ERROR))
    else $error("frame byte reported with a status outside a frame");

  // The last frame byte always leaves the in-frame status.
  a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |->
      (out_payload_valid && (out_status == ST_COMPLETE || out_status == ST_ERROR)))
    else $error("frame end reported without completing the frame");

  // The frame type byte itself is never an ADC sample.
  a_adc_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_adc_payload) |-> (out_payload_valid && out_payload_index != '0))
    else $error("ADC flag on a non-frame byte or on the frame type byte");
`endif

endmodule

>>> sim/tb_length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  localparam int unsigned MAX_LEN = MAX_FRAME_LEN_DEF;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] byte_in;
  } link_item_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = 1'b0;
  logic [BYTE_W-1:0]    in_byte_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_payload_valid;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [INDEX_W-1:0]   out_payload_index;
  logic                 out_frame_end;
  logic                 out_adc_payload;

  length_prefixed_frame_deframer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_end     (out_frame_end),
    .out_adc_payload   (out_adc_payload)
  );

  // Marker settings as the block should hold them.
  logic [BYTE_W-1:0] mk_start = START_MARKER_RST;
  logic [BYTE_W-1:0] mk_end   = END_MARKER_RST;
  logic [BYTE_W-1:0] mk_adc   = ADC_TYPE_RST;

  // Parser state of the predictor.
  phase_t      pr_phase = PH_WAIT;
  logic [15:0] pr_len   = '0;
  logic [15:0] pr_count = '0;
  logic [7:0]  pr_type  = '0;

  link_item_t tx_items[$];
  res_t       predicted_results[$];
  int unsigned items_outstanding = 0;
  int unsigned items_pushed = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          in_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic res_t deframe_step(input logic act, input logic [BYTE_W-1:0] b);
    res_t        r;
    logic [15:0] idx;
    r = '0;
    if (act) begin
      pr_phase = PH_WAIT;
      pr_len   = '0;
      pr_count = '0;
      pr_type  = '0;
    end else begin
      case (pr_phase)
        PH_WAIT: begin
          if (b == mk_start) pr_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          pr_len   = {b, 8'h00};
          pr_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          pr_len   = {pr_len[15:8], b};
          pr_count = '0;
          pr_phase = (pr_len == 16'd0 || pr_len > MAX_LEN) ? PH_ERROR : PH_DATA;
        end
        PH_DATA: begin
          idx = pr_count;
          if (idx == 16'd0) pr_type = b;
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = idx[INDEX_W-1:0];
          // The sample region runs from index 1 up to len-4 inclusive.
          r.adc_payload = (pr_type == mk_adc) && (idx >= 16'd1) &&
                          ({1'b0, idx} + 17'd4 <= {1'b0, pr_len});
          pr_count = pr_count + 16'd1;
          if (pr_count == pr_len) begin
            r.frame_end = 1'b1;
            pr_phase = (b == mk_end) ? PH_DONE : PH_ERROR;
          end
        end
        default: ;
      endcase
    end
    case (pr_phase)
      PH_WAIT:              r.status = ST_WAIT;
      PH_LEN_HI, PH_LEN_LO: r.status = ST_LENGTH;
      PH_DATA:              r.status = ST_IN_FRAME;
      PH_DONE:              r.status = ST_COMPLETE;
      default:              r.status = ST_ERROR;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  // Sender: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    link_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = tx_items.pop_front();
        in_valid   <= 1'b1;
        in_action  <= it.action;
        in_byte_in <= it.byte_in;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Results are checked before the item taken at this edge is predicted.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_status, out_payload_valid, out_payload_byte, out_payload_index,
                out_frame_end, out_adc_payload};
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
        end else begin
          want = predicted_results.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              {"result %0d: got st=%0d pv=%0d b=%02h i=%0d end=%0d adc=%0d, ",
               "exp st=%0d pv=%0d b=%02h i=%0d end=%0d adc=%0d"},
              results_seen, got.status, got.payload_valid, got.payload_byte, got.payload_index,
              got.frame_end, got.adc_payload, want.status, want.payload_valid,
              want.payload_byte, want.payload_index, want.frame_end, want.adc_payload));
        end
        results_seen++;
      end
      in_taken = (in_valid === 1'b1 && in_stall === 1'b0);
      if (in_taken) begin
        predicted_results.push_back(deframe_step(in_action, in_byte_in));
        items_outstanding--;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  task automatic push_item(input logic act, input logic [BYTE_W-1:0] b);
    tx_items.push_back('{act, b});
    items_outstanding++;
    items_pushed++;
  endtask

  task automatic push_noise();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if (b == mk_start) b = b ^ 8'h01;
    push_item(1'b0, b);
  endtask

  // Start marker, big-endian length and, for a legal length, up to cut data bytes.
  task automatic push_frame(input int unsigned len, input bit adc_kind, input bit good_end,
                            input int unsigned cut);
    logic [15:0]       l16;
    logic [BYTE_W-1:0] b;
    l16 = len[15:0];
    push_item(1'b0, mk_start);
    push_item(1'b0, l16[15:8]);
    push_item(1'b0, l16[7:0]);
    if (len != 0 && len <= MAX_LEN) begin
      for (int unsigned i = 0; i < len && i < cut; i++) begin
        if (i == len - 1) b = good_end ? mk_end : ~mk_end;
        else if (i == 0 && adc_kind) b = mk_adc;
        else b = BYTE_W'($urandom_range(255));
        push_item(1'b0, b);
      end
    end
  endtask

  task automatic add_random_traffic(input int unsigned n_items);
    int unsigned first;
    int unsigned len;
    int unsigned sel;
    int unsigned cut;
    first = items_pushed;
    while (items_pushed - first < n_items) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) push_noise();
      sel = $urandom_range(99);
      if (sel < 6) len = 0;
      else if (sel < 12) len = $urandom_range(65535, MAX_LEN + 1);
      else len = $urandom_range(16, 1);
      // Now and then a restart lands in the middle of a frame.
      cut = ($urandom_range(99) < 8) ? $urandom_range(len) : len;
      push_frame(len, 1'($urandom_range(1)), $urandom_range(99) < 80, cut);
      repeat ($urandom_range(2)) push_item(1'b0, BYTE_W'($urandom_range(255)));
      push_item(1'b1, BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_START_MARKER: mk_start = val;
      REG_END_MARKER:   mk_end   = val;
      REG_ADC_TYPE:     mk_adc   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_outstanding != 0 || predicted_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 13;
    recv_idle_pct = 51;

    // Directed part with the reset markers.
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h00);
    push_frame(5, 1'b1, 1'b1, 5);
    push_item(1'b0, 8'hAA);
    push_item(1'b1, 8'h00);
    push_frame(0, 1'b0, 1'b1, 0);
    push_item(1'b1, 8'h5A);
    push_frame(16'hFFFF, 1'b0, 1'b1, 0);
    push_item(1'b1, 8'hA5);
    push_frame(2, 1'b1, 1'b0, 2);
    push_item(1'b1, 8'h00);
    wait_drained();

    add_random_traffic(180);
    wait_drained();

    write_cfg(REG_START_MARKER, 8'h00);
    write_cfg(REG_END_MARKER, 8'hFF);
    write_cfg(REG_ADC_TYPE, 8'h00);
    send_idle_pct = 51;
    recv_idle_pct = 13;
    add_random_traffic(180);
    wait_drained();

    write_cfg(REG_START_MARKER, 8'hFF);
    write_cfg(REG_END_MARKER, 8'h00);
    write_cfg(REG_ADC_TYPE, 8'hFF);
    add_random_traffic(140);
    wait_drained();

    write_cfg(REG_START_MARKER, BYTE_W'($urandom_range(255)));
    write_cfg(REG_END_MARKER, BYTE_W'($urandom_range(255)));
    write_cfg(REG_ADC_TYPE, BYTE_W'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_traffic(140);
    // A frame with the largest legal length, cut short, then one just past it.
    push_frame(MAX_LEN, 1'b1, 1'b1, 20);
    push_item(1'b1, 8'h3C);
    push_frame(MAX_LEN + 1, 1'b0, 1'b1, 0);
    push_item(1'b1, 8'hC3);
    add_random_traffic(80);
    wait_drained();

    repeat (10) @(negedge clk);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    if (mismatches == 0) begin
      $display("length_prefixed_frame_deframer test passed");
    end else begin
      $display("length_prefixed_frame_deframer test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("length_prefixed_frame_deframer test failed");
    $finish;
  end

endmodule
